### rtl/core/ctcb_pkg.sv
// ----------------------------------------------------------------------------
// ctcb_pkg
// Shared codes and control types for the COO to CSR builder.
// ----------------------------------------------------------------------------
package ctcb_pkg;

    // Input action codes (carried on s_axis_tuser)
    localparam logic ACT_TRIPLET = 1'b0;
    localparam logic ACT_FINISH  = 1'b1;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_FILL  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ROW_ORDER = 3'd1,
        ST_ROW_RANGE = 3'd2,
        ST_COL_RANGE = 3'd3,
        ST_TOO_MANY  = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // Control part of one queued command
    typedef struct packed {
        logic    has_fill;
        t_kind   kind;
        t_status status;
    } t_cmd_ctl;

    localparam int CMD_CTL_W = $bits(t_cmd_ctl);

endpackage

### rtl/core/ctcb_front.sv
// ----------------------------------------------------------------------------
// ctcb_front
// Accepts items, checks them against the matrix state and issues commands.
// ----------------------------------------------------------------------------
module ctcb_front
    import ctcb_pkg::*;
#(
    parameter int ROW_BITS = 20,
    parameter int COL_BITS = 20,
    parameter int NNZ_BITS = 32,
    parameter int CFG_W    = 21
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [ROW_BITS-1:0] i_row,
    input  logic [COL_BITS-1:0] i_column,
    input  logic [63:0]         i_value,
    input  logic                i_full,
    output logic                o_push,
    output t_cmd_ctl            o_ctl,
    output logic [ROW_BITS:0]   o_fill_first,
    output logic [ROW_BITS:0]   o_fill_last,
    output logic [NNZ_BITS-1:0] o_offset,
    output logic [COL_BITS-1:0] o_column,
    output logic [63:0]         o_value
);

    localparam int PTR_W = ROW_BITS + 1;
    localparam int CNT_W = COL_BITS + 1;

    logic [PTR_W-1:0]    r_row_count;
    logic [CNT_W-1:0]    r_col_count;
    logic [PTR_W-1:0]    r_next_fill, n_next_fill;
    logic [NNZ_BITS-1:0] r_entry_count, n_entry_count;
    t_status             r_error, n_error;

    logic             accept;
    logic [PTR_W-1:0] row_ext;
    logic [PTR_W-1:0] row_plus;
    logic [CNT_W-1:0] col_ext;
    logic             order_bad;
    logic             nonzero;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign row_ext   = {1'b0, i_row};
    assign row_plus  = row_ext + PTR_W'(1);
    assign col_ext   = {1'b0, i_column};
    assign order_bad = (r_next_fill != '0) && (row_plus < r_next_fill);
    // sign bit ignored: both zeros drop
    assign nonzero   = |i_value[62:0];

    always_comb begin
        n_next_fill   = r_next_fill;
        n_entry_count = r_entry_count;
        n_error       = r_error;
        o_push        = 1'b0;
        o_ctl         = '{has_fill: 1'b0, kind: KIND_DONE, status: ST_OK};
        o_fill_first  = r_next_fill;
        o_fill_last   = '0;
        o_offset      = r_entry_count;
        o_column      = '0;
        o_value       = '0;
        if (accept) begin
            if (i_action == ACT_FINISH) begin
                o_push = 1'b1;
                if (r_error != ST_OK) begin
                    o_ctl.status = r_error;
                end else if (r_entry_count == '0) begin
                    o_ctl.status = ST_EMPTY;
                end else begin
                    o_ctl.has_fill = (r_next_fill <= r_row_count);
                    o_fill_last    = r_row_count;
                end
                n_next_fill   = '0;
                n_entry_count = '0;
                n_error       = ST_OK;
            end else if (nonzero) begin
                o_push = 1'b1;
                if (r_error != ST_OK) begin
                    o_ctl.status = r_error;
                end else if (order_bad) begin
                    o_ctl.status = ST_ROW_ORDER;
                    n_error      = ST_ROW_ORDER;
                end else if (row_ext >= r_row_count) begin
                    o_ctl.status = ST_ROW_RANGE;
                    n_error      = ST_ROW_RANGE;
                end else if (col_ext >= r_col_count) begin
                    o_ctl.status = ST_COL_RANGE;
                    n_error      = ST_COL_RANGE;
                end else if (&r_entry_count) begin
                    o_ctl.status = ST_TOO_MANY;
                    n_error      = ST_TOO_MANY;
                end else begin
                    o_ctl.kind     = KIND_ENTRY;
                    o_ctl.has_fill = (r_next_fill <= row_ext);
                    o_fill_last    = row_ext;
                    o_column       = i_column;
                    o_value        = i_value;
                    n_next_fill    = row_plus;
                    n_entry_count  = r_entry_count + NNZ_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= PTR_W'(1);
            r_col_count   <= CNT_W'(1);
            r_next_fill   <= '0;
            r_entry_count <= '0;
            r_error       <= ST_OK;
        end else begin
            if (i_cfg_we && i_cfg_addr == REG_ROW_COUNT) begin
                r_row_count <= i_cfg_data[PTR_W-1:0];
            end
            if (i_cfg_we && i_cfg_addr == REG_COL_COUNT) begin
                r_col_count <= i_cfg_data[CNT_W-1:0];
            end
            r_next_fill   <= n_next_fill;
            r_entry_count <= n_entry_count;
            r_error       <= n_error;
        end
    end

endmodule

### rtl/core/ctcb_fifo.sv
// ----------------------------------------------------------------------------
// ctcb_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ctcb_fifo
    import ctcb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        bump = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/core/ctcb_back.sv
// ----------------------------------------------------------------------------
// ctcb_back
// Expands queued commands into one or two result transfers.
// ----------------------------------------------------------------------------
module ctcb_back
    import ctcb_pkg::*;
#(
    parameter int ROW_BITS = 20,
    parameter int COL_BITS = 20,
    parameter int NNZ_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_pop,
    input  t_cmd_ctl            i_ctl,
    input  logic [ROW_BITS:0]   i_fill_first,
    input  logic [ROW_BITS:0]   i_fill_last,
    input  logic [NNZ_BITS-1:0] i_offset,
    input  logic [COL_BITS-1:0] i_column,
    input  logic [63:0]         i_value,
    input  logic                i_ready,
    output logic                o_valid,
    output t_kind               o_kind,
    output logic                o_last,
    output logic [ROW_BITS:0]   o_row_first,
    output logic [ROW_BITS:0]   o_row_last,
    output logic [NNZ_BITS-1:0] o_offset,
    output logic [COL_BITS-1:0] o_column,
    output logic [63:0]         o_value,
    output t_status             o_status
);

    logic                r_busy;
    logic                r_fill_pend;
    t_cmd_ctl            r_ctl;
    logic [ROW_BITS:0]   r_first;
    logic [ROW_BITS:0]   r_lastrow;
    logic [NNZ_BITS-1:0] r_offset;
    logic [COL_BITS-1:0] r_column;
    logic [63:0]         r_value;
    logic                take_next;

    // free for a new command once the main result leaves
    assign take_next = !r_busy || (i_ready && !r_fill_pend);
    assign o_pop     = i_valid && take_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fill_pend <= 1'b0;
        end else if (r_busy && r_fill_pend && i_ready) begin
            r_fill_pend <= 1'b0;
        end else if (take_next) begin
            r_busy      <= i_valid;
            r_fill_pend <= i_valid && i_ctl.has_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl     <= i_ctl;
            r_first   <= i_fill_first;
            r_lastrow <= i_fill_last;
            r_offset  <= i_offset;
            r_column  <= i_column;
            r_value   <= i_value;
        end
    end

    always_comb begin
        o_valid  = r_busy;
        o_offset = r_offset;
        if (r_fill_pend) begin
            o_kind      = KIND_FILL;
            o_last      = 1'b0;
            o_row_first = r_first;
            o_row_last  = r_lastrow;
            o_column    = '0;
            o_value     = '0;
            o_status    = ST_OK;
        end else begin
            o_kind      = r_ctl.kind;
            o_last      = 1'b1;
            o_row_first = '0;
            o_row_last  = '0;
            o_column    = r_column;
            o_value     = r_value;
            o_status    = r_ctl.status;
        end
    end

endmodule

### rtl/core/coo_to_csr_builder.sv
// ----------------------------------------------------------------------------
// coo_to_csr_builder
// Turns row-ordered COO triplets into CSR row pointer fills and entries.
// ----------------------------------------------------------------------------
//  Channel   Direction  tuser          tlast   tdata (lowest bit up)
//  s_axis    in         action         -       row, column, value
//  m_axis    out        kind           last    row_first, row_last, offset,
//                                              out_column, out_value, status
//  i_cfg_*   in         write enable, 1-bit index, data (no read-back)
//
//  One item is taken per cycle while the queue is not full; a triplet that
//  needs a pointer fill gives two result transfers, the fill and then the entry.
//  The front checks and updates the row/count state in the accept cycle; a
//  four-entry queue holds commands; the back register presents results.
//  An accepted item reaches the output through the queue and then the back register.
//  Reset clears the matrix state, the queue and the output stage; row_count
//  and col_count return to one. Either side may stall without the other.
// ----------------------------------------------------------------------------
module coo_to_csr_builder
    import ctcb_pkg::*;
#(
    parameter int ROW_BITS = 20,
    parameter int COL_BITS = 20,
    parameter int NNZ_BITS = 32,
    localparam int CFG_W    = (ROW_BITS > COL_BITS) ? ROW_BITS + 1 : COL_BITS + 1,
    localparam int IN_W     = ROW_BITS + COL_BITS + 64,
    localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8,
    localparam int PTR_W    = ROW_BITS + 1,
    localparam int OUT_W    = 2 * PTR_W + NNZ_BITS + COL_BITS + 64 + 3,
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_addr,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TD_W-1:0]        s_axis_tdata,  // row, column, value
    input  logic                      s_axis_tuser,  // action
    // output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TD_W-1:0]       m_axis_tdata,  // row_first, row_last, offset,
                                                     // out_column, out_value, status
    output logic [1:0]                m_axis_tuser,  // kind
    output logic                      m_axis_tlast
);

    localparam int CMD_W    = CMD_CTL_W + 2 * PTR_W + NNZ_BITS + COL_BITS + 64;

    // front to queue
    logic                f_push;
    t_cmd_ctl            f_ctl;
    logic [PTR_W-1:0]    f_fill_first, f_fill_last;
    logic [NNZ_BITS-1:0] f_offset;
    logic [COL_BITS-1:0] f_column;
    logic [63:0]         f_value;
    logic                q_full;

    // queue to back
    logic                q_valid, q_pop;
    logic [CMD_W-1:0]    q_data;
    t_cmd_ctl            b_ctl;
    logic [PTR_W-1:0]    b_fill_first, b_fill_last;
    logic [NNZ_BITS-1:0] b_offset;
    logic [COL_BITS-1:0] b_column;
    logic [63:0]         b_value;

    // result fields
    t_kind               o_kind;
    logic [PTR_W-1:0]    o_row_first, o_row_last;
    logic [NNZ_BITS-1:0] o_offset;
    logic [COL_BITS-1:0] o_column;
    logic [63:0]         o_value;
    t_status             o_status;

    ctcb_front #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS),
        .NNZ_BITS (NNZ_BITS),
        .CFG_W    (CFG_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_row        (s_axis_tdata[ROW_BITS-1:0]),
        .i_column     (s_axis_tdata[ROW_BITS +: COL_BITS]),
        .i_value      (s_axis_tdata[ROW_BITS + COL_BITS +: 64]),
        .i_full       (q_full),
        .o_push       (f_push),
        .o_ctl        (f_ctl),
        .o_fill_first (f_fill_first),
        .o_fill_last  (f_fill_last),
        .o_offset     (f_offset),
        .o_column     (f_column),
        .o_value      (f_value)
    );

    ctcb_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_fill_first, f_fill_last, f_offset, f_column, f_value}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {b_ctl, b_fill_first, b_fill_last, b_offset, b_column, b_value} = q_data;

    ctcb_back #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS),
        .NNZ_BITS (NNZ_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (q_pop),
        .i_ctl        (b_ctl),
        .i_fill_first (b_fill_first),
        .i_fill_last  (b_fill_last),
        .i_offset     (b_offset),
        .i_column     (b_column),
        .i_value      (b_value),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_kind       (o_kind),
        .o_last       (m_axis_tlast),
        .o_row_first  (o_row_first),
        .o_row_last   (o_row_last),
        .o_offset     (o_offset),
        .o_column     (o_column),
        .o_value      (o_value),
        .o_status     (o_status)
    );

    // pack results, first field lowest, zero-padded to whole bytes
    assign m_axis_tuser = o_kind;
    assign m_axis_tdata = OUT_TD_W'({o_status, o_value, o_column, o_offset,
                                     o_row_last, o_row_first});

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a fill is never the final result of an item and never carries a fault
    a_fill_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && o_kind == KIND_FILL |-> !m_axis_tlast && o_status == ST_OK)
        else $error("fill result marked last or faulted");

    // a fill range is never empty
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && o_kind == KIND_FILL |-> o_row_first <= o_row_last)
        else $error("empty fill range issued");

    // an entry closes its item and is always good
    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && o_kind == KIND_ENTRY |-> m_axis_tlast && o_status == ST_OK)
        else $error("entry result malformed");

    // the front never pushes into a full queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !f_push)
        else $error("command queue overrun");

endmodule

### verif/coo_to_csr_builder_tb.sv
// ----------------------------------------------------------------------------
// coo_to_csr_builder_tb
// Self-checking bench for the COO to CSR builder: triplets and finish items go
// in on the input stream, and every pointer fill, entry and done/fault result
// on the output stream is checked against an in-bench model of the row pointer
// state. Directed cases come first, then a back-pressure case, then random
// matrices under a range of row/column counts with random idling on both sides.
// ----------------------------------------------------------------------------
module coo_to_csr_builder_tb;
    import ctcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_W  = 20;
    localparam int COL_W  = 20;
    localparam int PTR_W  = ROW_W + 1;
    localparam int NNZ_W  = 32;
    localparam int CFG_DW = 21;
    localparam int IN_W   = 104;           // row, column, value
    localparam int OUT_W  = 168;           // 161 bits of fields, zero padded

    // bit positions of the result fields in m_axis_tdata
    localparam int RF_LSB  = 0;
    localparam int RL_LSB  = RF_LSB + PTR_W;
    localparam int OFF_LSB = RL_LSB + PTR_W;
    localparam int COL_LSB = OFF_LSB + NNZ_W;
    localparam int VAL_LSB = COL_LSB + COL_W;
    localparam int ST_LSB  = VAL_LSB + 64;

    localparam int ITEM_TARGET  = 1150;
    localparam int SETTLE_LEN   = 6;       // covers the queue and the back register
    localparam int HOLDOFF_LEN  = 300;
    localparam int LIMIT_CYCLES = 500000;

    typedef struct {
        t_kind              kind;
        logic [PTR_W-1:0]   row_first;
        logic [PTR_W-1:0]   row_last;
        logic [NNZ_W-1:0]   offset;
        logic [COL_W-1:0]   column;
        logic [63:0]        value;
        t_status            status;
        logic               last;
    } t_csr_result;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_addr    = REG_ROW_COUNT;
    logic [CFG_DW-1:0]   i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;   // row, column, value
    logic                s_axis_tuser  = ACT_TRIPLET;  // action
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;   // row_first, row_last, offset,
                                         // out_column, out_value, status
    logic [1:0]          m_axis_tuser;   // kind
    logic                m_axis_tlast;

    coo_to_csr_builder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Row pointer model: own copy of the registers and the matrix state
    // ------------------------------------------------------------------------
    logic [PTR_W-1:0]  cfg_rows = 21'd1;
    logic [PTR_W-1:0]  cfg_cols = 21'd1;
    logic [PTR_W-1:0]  fill_ptr = '0;     // next row pointer still unwritten
    logic [NNZ_W-1:0]  nnz      = '0;     // entries stored in this matrix
    t_status           fault    = ST_OK;  // latched until finish

    t_csr_result csr_expect_q[$];

    // scoreboard and coverage tallies
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int fills_seen    = 0;
    int entries_seen  = 0;
    int dones_seen    = 0;
    int status_seen[6];
    int input_stalls  = 0;
    int cycle_count   = 0;

    // sender burst control and receiver hold-off request
    int src_burst_left = 0;
    bit src_steady     = 1'b0;
    int sink_holdoff   = 0;

    function automatic void add_result(t_kind k, logic [PTR_W-1:0] first,
                                       logic [PTR_W-1:0] lst_row,
                                       logic [NNZ_W-1:0] off,
                                       logic [COL_W-1:0] col, logic [63:0] val,
                                       t_status st, logic lst);
        t_csr_result r;
        r.kind      = k;
        r.row_first = first;
        r.row_last  = lst_row;
        r.offset    = off;
        r.column    = col;
        r.value     = val;
        r.status    = st;
        r.last      = lst;
        csr_expect_q = {csr_expect_q, r};
    endfunction

    // Work out what one accepted item produces and advance the model state.
    function automatic void csr_predict(logic act, logic [ROW_W-1:0] row,
                                        logic [COL_W-1:0] col, logic [63:0] val);
        if (act == ACT_FINISH) begin
            if (fault != ST_OK) begin
                add_result(KIND_DONE, '0, '0, nnz, '0, '0, fault, 1'b1);
            end else if (nnz == 0) begin
                add_result(KIND_DONE, '0, '0, '0, '0, '0, ST_EMPTY, 1'b1);
            end else begin
                // pointers left over up to and including row_count
                if (fill_ptr <= cfg_rows)
                    add_result(KIND_FILL, fill_ptr, cfg_rows, nnz, '0, '0, ST_OK, 1'b0);
                add_result(KIND_DONE, '0, '0, nnz, '0, '0, ST_OK, 1'b1);
            end
            fill_ptr = '0;
            nnz      = '0;
            fault    = ST_OK;
        end else if (val[62:0] != '0) begin
            // plus and minus zero are dropped above; faults in priority order
            if (fault == ST_OK) begin
                if (fill_ptr != 0 && {1'b0, row} < fill_ptr - 1'b1)
                    fault = ST_ROW_ORDER;
                else if ({1'b0, row} >= cfg_rows)
                    fault = ST_ROW_RANGE;
                else if ({1'b0, col} >= cfg_cols)
                    fault = ST_COL_RANGE;
                else if (nnz == '1)
                    fault = ST_TOO_MANY;
            end
            if (fault == ST_OK) begin
                if (fill_ptr <= {1'b0, row})
                    add_result(KIND_FILL, fill_ptr, {1'b0, row}, nnz, '0, '0, ST_OK, 1'b0);
                add_result(KIND_ENTRY, '0, '0, nnz, col, val, ST_OK, 1'b1);
                fill_ptr = {1'b0, row} + 1'b1;
                nnz      = nnz + 1'b1;
            end else begin
                add_result(KIND_DONE, '0, '0, nnz, '0, '0, fault, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare every output transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_csr_result want;
        logic [PTR_W-1:0] got_first, got_lrow;
        logic [NNZ_W-1:0] got_off;
        logic [COL_W-1:0] got_col;
        logic [63:0]      got_val;
        logic [2:0]       got_st;
        if (i_rst_n) begin
            if (s_axis_tvalid && !s_axis_tready)
                input_stalls++;
            if (m_axis_tvalid && m_axis_tready) begin
                got_first = m_axis_tdata[RF_LSB  +: PTR_W];
                got_lrow  = m_axis_tdata[RL_LSB  +: PTR_W];
                got_off   = m_axis_tdata[OFF_LSB +: NNZ_W];
                got_col   = m_axis_tdata[COL_LSB +: COL_W];
                got_val   = m_axis_tdata[VAL_LSB +: 64];
                got_st    = m_axis_tdata[ST_LSB  +: 3];
                results_seen++;
                if (csr_expect_q.size() == 0) begin
                    // nothing was due: count it with the mismatches
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result kind=%0d offset=%0d status=%0d",
                                 $realtime, m_axis_tuser, got_off, got_st);
                end else begin
                    want = csr_expect_q.pop_front();
                    case (want.kind)
                        KIND_FILL:  fills_seen++;
                        KIND_ENTRY: entries_seen++;
                        default:    dones_seen++;
                    endcase
                    if (want.kind == KIND_DONE)
                        status_seen[want.status]++;
                    if (m_axis_tuser !== want.kind     || got_first !== want.row_first ||
                        got_lrow     !== want.row_last || got_off   !== want.offset    ||
                        got_col      !== want.column   || got_val   !== want.value     ||
                        got_st       !== want.status   || m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, results_seen);
                            $display("  want kind=%0d first=%0d last_row=%0d off=%0d col=%0d",
                                     want.kind, want.row_first, want.row_last,
                                     want.offset, want.column);
                            $display("       value=%h status=%0d tlast=%b",
                                     want.value, want.status, want.last);
                            $display("  got  kind=%0d first=%0d last_row=%0d off=%0d col=%0d",
                                     m_axis_tuser, got_first, got_lrow, got_off, got_col);
                            $display("       value=%h status=%0d tlast=%b",
                                     got_val, got_st, m_axis_tlast);
                        end
                    end
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, csr_expect_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its own stall pattern, switching mode after each random span;
    // a hold-off request from a test takes priority and is counted down here
    // ------------------------------------------------------------------------
    initial begin : sink_pattern
        int mode;
        int span;
        int tick;
        mode = 0;
        span = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (sink_holdoff > 0) begin
                sink_holdoff--;
                m_axis_tready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;                        // free flow
                    1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_axis_tready <= ($urandom_range(0, 9) < 3);
                    default: m_axis_tready <= (tick % 3 == 0);             // periodic
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: one transfer per call, entered and left at a falling edge.
    // Gaps fall between bursts of random length unless the sender is steady.
    // ------------------------------------------------------------------------
    task automatic push_item(input logic act, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [63:0] val);
        int gap;
        if (src_burst_left == 0) begin
            gap = src_steady ? 0 : $urandom_range(1, 8);
            // now and then a long stretch with no idling at all
            src_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        src_burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {val, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        csr_predict(act, row, col, val);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every due result has been taken, then let the
    // pipeline settle so a dropped zero triplet cannot still be in flight.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (csr_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_LEN) @(negedge i_clk);
        src_burst_left = 0;
    endtask

    // Write both registers while the block is idle.
    task automatic set_dims(input logic [CFG_DW-1:0] rows, input logic [CFG_DW-1:0] cols);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_ROW_COUNT;
        i_cfg_data <= rows;
        @(negedge i_clk);
        i_cfg_addr <= REG_COL_COUNT;
        i_cfg_data <= cols;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_rows = rows;
        cfg_cols = cols;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero values dropped, first fill, same-row entry, gap fill, finish fill,
    // then an empty matrix.
    task automatic test_basic_build();
        set_dims(21'd8, 21'd8);
        push_item(ACT_TRIPLET, 20'd0, 20'd0, 64'h0000_0000_0000_0000);   // +0.0
        push_item(ACT_TRIPLET, 20'd0, 20'd0, 64'h8000_0000_0000_0000);   // -0.0
        push_item(ACT_TRIPLET, 20'd0, 20'd0, 64'h3FF0_0000_0000_0000);
        push_item(ACT_TRIPLET, 20'd0, 20'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(ACT_TRIPLET, 20'd3, 20'd2, 64'h8000_0000_0000_0001);
        push_item(ACT_FINISH,  20'hFFFFF, 20'hFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
    endtask

    // Row order, row range and column range faults, latching, and finish with a fault pending.
    task automatic test_faults();
        set_dims(21'd8, 21'd8);
        push_item(ACT_TRIPLET, 20'd5, 20'd1, 64'h4000_0000_0000_0000);
        push_item(ACT_TRIPLET, 20'd2, 20'd1, 64'h4000_0000_0000_0000);   // row goes back
        push_item(ACT_TRIPLET, 20'd6, 20'd1, 64'h4000_0000_0000_0000);   // latched
        push_item(ACT_TRIPLET, 20'd7, 20'd1, 64'h8000_0000_0000_0000);   // dropped
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
        push_item(ACT_TRIPLET, 20'd8, 20'd0, 64'h0000_0000_0000_0001);   // row past end
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
        push_item(ACT_TRIPLET, 20'd0, 20'd8, 64'h0000_0000_0000_0001);   // column past end
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
    endtask

    // Largest sizes, a row count shrunk below the fill pointer mid-matrix,
    // and zero register values.
    task automatic test_extremes();
        set_dims(21'd1048576, 21'd1048576);
        push_item(ACT_TRIPLET, 20'hFFFFF, 20'hFFFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
        set_dims(21'd4, 21'd4);
        push_item(ACT_TRIPLET, 20'd3, 20'd3, 64'hC000_0000_0000_0000);
        set_dims(21'd2, 21'd4);              // fill pointer now beyond row_count
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
        set_dims(21'd0, 21'd8);
        push_item(ACT_TRIPLET, 20'd0, 20'd0, 64'h3FF0_0000_0000_0000);
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
        set_dims(21'd8, 21'd0);
        push_item(ACT_TRIPLET, 20'd0, 20'd0, 64'h3FF0_0000_0000_0000);
        push_item(ACT_FINISH,  20'd0, 20'd0, 64'd0);
    endtask

    // Receiver holds off while the sender keeps offering: the queue fills and
    // the input stalls; then the sender waits for everything to drain.
    task automatic test_backpressure();
        set_dims(21'd32, 21'd32);
        src_steady = 1'b1;
        @(posedge i_clk);
        sink_holdoff = HOLDOFF_LEN;
        @(negedge i_clk);
        for (int i = 0; i < 30; i++)
            push_item(ACT_TRIPLET, ROW_W'(i), COL_W'(i % 32),
                      {$urandom, $urandom} | 64'd1);
        push_item(ACT_FINISH, 20'd0, 20'd0, 64'd0);
        src_steady = 1'b0;
        wait_drained();
    endtask

    // One random matrix: mostly well-formed rising rows with random content,
    // with some noise items and out-of-order rows mixed in.
    task automatic send_matrix(input logic [CFG_DW-1:0] rows, input logic [CFG_DW-1:0] cols);
        int len, cur, rmax, pick, step;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [63:0] val;
        len  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        rmax = (rows == 0) ? 0 : ((rows > 21'd1048576) ? 1048575 : int'(rows) - 1);
        cur  = $urandom_range(0, (rmax < 7) ? rmax : 7);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                row = ROW_W'($urandom);
                col = COL_W'($urandom);
            end else if (pick < 8) begin
                row = ROW_W'($urandom_range(0, cur));
                col = (cols == 0) ? COL_W'($urandom) : COL_W'($urandom_range(0, cols - 1));
            end else begin
                step = $urandom_range(0, 9);
                if (step >= 5 && step < 8)
                    cur = cur + $urandom_range(1, 3);
                else if (step == 8)
                    cur = $urandom_range(cur, rmax);
                else if (step == 9)
                    cur = rmax;
                if (cur > rmax)
                    cur = rmax;
                row = ROW_W'(cur);
                col = (cols == 0) ? COL_W'($urandom) : COL_W'($urandom_range(0, cols - 1));
            end
            case ($urandom_range(0, 9))
                0:       val = {1'($urandom_range(0, 1)), 63'd0};
                1: begin
                    case ($urandom_range(0, 3))
                        0:       val = 64'hFFFF_FFFF_FFFF_FFFF;
                        1:       val = 64'h8000_0000_0000_0001;
                        2:       val = 64'h3FF0_0000_0000_0000;
                        default: val = 64'h0000_0000_0000_0001;
                    endcase
                end
                default: val = {$urandom, $urandom};
            endcase
            push_item(ACT_TRIPLET, row, col, val);
        end
        push_item(ACT_FINISH, ROW_W'($urandom), COL_W'($urandom), {$urandom, $urandom});
    endtask

    // Random matrices under a rotating set of row/column counts.
    task automatic test_random_matrices();
        logic [CFG_DW-1:0] rows, cols;
        int budget;
        for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
            case (phase % 7)
                0: begin
                    rows = CFG_DW'($urandom_range(1, 16));
                    cols = CFG_DW'($urandom_range(1, 16));
                end
                1: begin
                    rows = 21'd1;
                    cols = 21'd1;
                end
                2: begin
                    rows = 21'd1048576;
                    cols = 21'd1048576;
                end
                3: begin
                    rows = '1;
                    cols = '1;
                end
                4: begin
                    rows = CFG_DW'($urandom_range(1, 4096));
                    cols = CFG_DW'($urandom_range(1, 2097151));
                end
                5: begin
                    rows = CFG_DW'($urandom_range(1, 64));
                    cols = CFG_DW'($urandom_range(1, 64));
                end
                default: begin
                    // one of the two registers at zero
                    rows = $urandom_range(0, 1) ? 21'd0 : 21'd8;
                    cols = (rows == 0) ? 21'd8 : 21'd0;
                end
            endcase
            set_dims(rows, cols);
            budget = items_sent + ((phase % 7 == 6) ? 20 : $urandom_range(60, 120));
            while (items_sent < budget && items_sent < ITEM_TARGET)
                send_matrix(rows, cols);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_build();
        test_faults();
        test_extremes();
        test_backpressure();
        test_random_matrices();

        // drain, then give the block time to show any stray result
        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("covered %0d input transfers, %0d results: %0d fills, %0d entries, %0d done",
                 items_sent, results_seen, fills_seen, entries_seen, dones_seen);
        $display("faults seen: order %0d, row range %0d, column range %0d, empty %0d; %s %0d",
                 status_seen[ST_ROW_ORDER], status_seen[ST_ROW_RANGE],
                 status_seen[ST_COL_RANGE], status_seen[ST_EMPTY],
                 "input stall cycles", input_stalls);
        if (mismatches == 0 && csr_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, csr_expect_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
